[hw/rtl/hgp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgp_pkg
// Types and fixed widths shared by the phase density pipeline.
// ----------------------------------------------------------------------------
package hgp_pkg;

  localparam int unsigned T30_W  = 46;
  localparam int unsigned N30_W  = 31;
  localparam int unsigned Q_W    = N30_W + 30;
  localparam int unsigned RAD_W  = T30_W + 16;
  localparam int unsigned S_W    = RAD_W / 2;
  localparam int unsigned VNUM_W = 54;
  localparam int unsigned V_W    = 46;
  localparam int unsigned X_W    = 64;
  localparam int unsigned C_W    = 29;

  localparam logic [VNUM_W-1:0] V_NUM     = {1'b1, {(VNUM_W-1){1'b0}}};
  localparam logic [C_W-1:0]    INV_4PI   = 29'h145F306E;
  localparam logic [31:0]       SAT_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } hgp_in_t;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } hgp_out_t;

  typedef struct packed {
    logic valid;
    logic t_zero;
    logic n_zero;
  } hgp_side_t;

endpackage

[hw/rtl/hgp_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgp_delay
// Fixed-length register line for alignment of parallel paths.
// ----------------------------------------------------------------------------
module hgp_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) line_q[i] <= '0;
    end else begin
      line_q[0] <= d_i;
      for (int i = 1; i < N; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[N-1];

endmodule

[hw/rtl/hgp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hgp_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_s;
    logic [NUM_W-1:0] quo_s;
    logic [NUM_W-1:0] num_s;
    logic [DEN_W-1:0] den_s;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign quo_s = '0;
      assign num_s = num_i;
      assign den_s = den_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign quo_s = quo_q[k-1];
      assign num_s = num_q[k-1];
      assign den_s = den_q[k-1];
    end

    assign sh   = {rem_s, num_s[NUM_W-1-k]};
    assign take = (sh >= {1'b0, den_s});
    assign diff = sh - {1'b0, den_s};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_q[k] <= {quo_s[NUM_W-2:0], take};
      num_q[k] <= num_s;
      den_q[k] <= den_s;
    end
  end

  assign quo_o = quo_q[NUM_W-1];

endmodule

[hw/rtl/hgp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgp_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module hgp_isqrt #(
  parameter int unsigned RAD_W = 16
) (
  input  logic                 clk_i,
  input  logic [RAD_W-1:0]     rad_i,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int unsigned R_W = RAD_W / 2;

  logic [R_W:0]       rem_q  [R_W];
  logic [R_W-1:0]     root_q [R_W];
  logic [RAD_W-1:0]   rad_q  [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [R_W:0]     rem_s;
    logic [R_W-1:0]   root_s;
    logic [RAD_W-1:0] rad_s;
    logic [R_W+2:0]   sh;
    logic [R_W+2:0]   trial;
    logic [R_W+2:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = rad_i;
    end else begin : g_next
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign rad_s  = rad_q[k-1];
    end

    assign sh    = {rem_s, rad_s[RAD_W-1-2*k -: 2]};
    assign trial = {1'b0, root_s, 2'b01};
    assign take  = (sh >= trial);
    assign diff  = sh - trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? diff[R_W:0] : sh[R_W:0];
      root_q[k] <= {root_s[R_W-2:0], take};
      rad_q[k]  <= rad_s;
    end
  end

  assign root_o = root_q[R_W-1];

endmodule

[hw/rtl/hgp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgp_front
// Dot product, clamp, t and 1-g^2 in four register stages.
// ----------------------------------------------------------------------------
module hgp_front #(
  parameter int unsigned F = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  hgp_pkg::hgp_in_t         data_i,
  input  logic signed [15:0]       g_i,
  output hgp_pkg::hgp_side_t       side_o,
  output logic [hgp_pkg::T30_W-1:0] t30_o,
  output logic [hgp_pkg::N30_W-1:0] n30_o
);
  import hgp_pkg::*;

  localparam logic signed [63:0] ONE2  = 64'sd1 <<< (2 * F);
  localparam logic signed [63:0] SCALE = 64'sd1 <<< (F + 30);
  localparam int unsigned SH_DN = (2 * F >= 30) ? 2 * F - 30 : 0;
  localparam int unsigned SH_UP = (2 * F < 30) ? 30 - 2 * F : 0;

  logic [3:0] vld_q;

  // stage 1
  logic signed [31:0] px_q, py_q, pz_q, gsq_q;
  logic signed [15:0] g1_q;
  // stage 2
  logic signed [31:0] d_q;
  logic [63:0]        gg2_q;
  logic signed [15:0] g2_q;
  // stage 3
  logic signed [63:0] gd_q;
  logic [63:0]        gg3_q;
  // stage 4
  logic [T30_W-1:0]   t30_q;
  logic [N30_W-1:0]   n30_q;
  logic               tz_q, nz_q;

  logic signed [63:0] dot_d, dcl_d, dsh_d, t_d, num_d;
  logic [63:0]        t_pos, n_pos, t_shr, n_shr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= data_i.in_x * data_i.out_x;
    py_q  <= data_i.in_y * data_i.out_y;
    pz_q  <= data_i.in_z * data_i.out_z;
    gsq_q <= g_i * g_i;
    g1_q  <= g_i;
  end

  always_comb begin
    dot_d = 64'(px_q) + 64'(py_q) + 64'(pz_q);
    if (dot_d > ONE2) begin
      dcl_d = ONE2;
    end else if (dot_d < -ONE2) begin
      dcl_d = -ONE2;
    end else begin
      dcl_d = dot_d;
    end
    if (2 * F >= 30) begin
      dsh_d = (dcl_d >= 0) ? (dcl_d >>> SH_DN) : -((-dcl_d) >>> SH_DN);
    end else begin
      dsh_d = dcl_d <<< SH_UP;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= dsh_d[31:0];
    gg2_q <= {32'd0, gsq_q} << (30 - F);
    g2_q  <= g1_q;
  end

  always_ff @(posedge clk_i) begin
    gd_q  <= 64'(g2_q * d_q) <<< 1;
    gg3_q <= gg2_q;
  end

  always_comb begin
    t_d   = SCALE + $signed(gg3_q) + gd_q;
    num_d = SCALE - $signed(gg3_q);
    t_pos = (t_d < 0) ? 64'd0 : t_d;
    n_pos = (num_d < 0) ? 64'd0 : num_d;
    t_shr = t_pos >> F;
    n_shr = n_pos >> F;
  end

  always_ff @(posedge clk_i) begin
    t30_q <= t_shr[T30_W-1:0];
    n30_q <= n_shr[N30_W-1:0];
    tz_q  <= (t_shr == 64'd0);
    nz_q  <= (n_shr == 64'd0);
  end

  assign side_o = '{valid: vld_q[3], t_zero: tz_q, n_zero: nz_q};
  assign t30_o  = t30_q;
  assign n30_o  = n30_q;

endmodule

[hw/rtl/hgp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgp_back
// q * v, scale by 1/(4 pi), saturation; four register stages.
// ----------------------------------------------------------------------------
module hgp_back #(
  parameter int unsigned OUT_F = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hgp_pkg::hgp_side_t      side_i,
  input  logic [hgp_pkg::Q_W-1:0] q_i,
  input  logic [hgp_pkg::V_W-1:0] v_i,
  output logic                    valid_o,
  output hgp_pkg::hgp_out_t       result_o
);
  import hgp_pkg::*;

  localparam int unsigned P_W  = Q_W + V_W;
  localparam int unsigned P2_W = X_W + C_W;

  logic [3:0] vld_q;
  logic [2:0] tz_q, nz_q;
  logic       ov2_q, ov3_q;

  logic [63:0]  ll_q;
  logic [45:0]  lh_q;
  logic [60:0]  hl_q;
  logic [42:0]  hh_q;
  logic [X_W-1:0] x_q;
  logic [60:0]  cl_q, ch_q;
  hgp_out_t     res_q;

  logic [P_W-1:0]  prod_d;
  logic [P2_W-1:0] prod2_d, shr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], side_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    tz_q <= {tz_q[1:0], side_i.t_zero};
    nz_q <= {nz_q[1:0], side_i.n_zero};
  end

  always_ff @(posedge clk_i) begin
    ll_q <= q_i[31:0] * v_i[31:0];
    lh_q <= 46'(q_i[31:0] * v_i[45:32]);
    hl_q <= 61'(q_i[60:32] * v_i[31:0]);
    hh_q <= 43'(q_i[60:32] * v_i[45:32]);
  end

  assign prod_d = P_W'(ll_q) + (P_W'(lh_q) << 32) + (P_W'(hl_q) << 32) + (P_W'(hh_q) << 64);

  always_ff @(posedge clk_i) begin
    x_q   <= prod_d[91:28];
    ov2_q <= |prod_d[P_W-1:92];
  end

  always_ff @(posedge clk_i) begin
    cl_q  <= 61'(x_q[31:0] * INV_4PI);
    ch_q  <= 61'(x_q[63:32] * INV_4PI);
    ov3_q <= ov2_q;
  end

  always_comb begin
    prod2_d = P2_W'(cl_q) + (P2_W'(ch_q) << 32);
    shr_d   = prod2_d >> (64 - OUT_F);
  end

  always_ff @(posedge clk_i) begin
    priority if (tz_q[2]) begin
      res_q <= '{density: SAT_VALUE, saturated: 1'b1};
    end else if (nz_q[2]) begin
      res_q <= '{density: 32'd0, saturated: 1'b0};
    end else if (ov3_q || (|shr_d[P2_W-1:32])) begin
      res_q <= '{density: SAT_VALUE, saturated: 1'b1};
    end else begin
      res_q <= '{density: shr_d[31:0], saturated: 1'b0};
    end
  end

  assign valid_o  = vld_q[3];
  assign result_o = res_q;

endmodule

[hw/rtl/henyey_greenstein_pdf_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// henyey_greenstein_pdf_unit
// Henyey-Greenstein phase density (1-g^2)/(4 pi t^1.5), t = 1+g^2+2g(wi.wo).
//
// Usage: write g (signed Q1.15) on the cfg channel while idle; ready is
// always high. Drive a direction pair on in_data_i with start high for
// one beat per cycle; busy stays low, so a new pair can enter every
// cycle. Each result appears on result_o for one cycle with result_valid_o
// high, in input order. The result path runs through the square root
// (31 stages) followed by the reciprocal divider (54 stages), plus four
// front and four back stages. Throughput: one item per cycle. Density is
// unsigned Q16.16; saturated flags t of zero or overflow. Reset clears g
// to zero and empties the pipeline; results cannot be held off by the
// receiver.
// ----------------------------------------------------------------------------
module henyey_greenstein_pdf_unit #(
  parameter int unsigned IN_FRAC_BITS  = 15,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [15:0] cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  hgp_pkg::hgp_in_t   in_data_i,
  output logic               result_valid_o,
  output hgp_pkg::hgp_out_t  result_o
);
  import hgp_pkg::*;

  localparam int unsigned MID_LAT = S_W + VNUM_W;
  localparam int unsigned Q_PAD   = MID_LAT - Q_W;

  logic signed [15:0] g_q;
  hgp_side_t          side_f, side_m;
  logic [T30_W-1:0]   t30;
  logic [N30_W-1:0]   n30;
  logic [Q_W-1:0]     q_raw, q_al;
  logic [S_W-1:0]     s_root;
  logic [VNUM_W-1:0]  v_full;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      g_q <= cfg_data_i;
    end
  end

  hgp_front #(.F(IN_FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .data_i  (in_data_i),
    .g_i     (g_q),
    .side_o  (side_f),
    .t30_o   (t30),
    .n30_o   (n30)
  );

  hgp_div #(.NUM_W(Q_W), .DEN_W(T30_W)) u_div_q (
    .clk_i (clk_i),
    .num_i ({n30, 30'd0}),
    .den_i (t30),
    .quo_o (q_raw)
  );

  hgp_delay #(.W(Q_W), .N(Q_PAD)) u_q_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (q_raw),
    .q_o    (q_al)
  );

  hgp_isqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  ({t30, 16'd0}),
    .root_o (s_root)
  );

  hgp_div #(.NUM_W(VNUM_W), .DEN_W(S_W)) u_div_v (
    .clk_i (clk_i),
    .num_i (V_NUM),
    .den_i (s_root),
    .quo_o (v_full)
  );

  hgp_delay #(.W($bits(hgp_side_t)), .N(MID_LAT)) u_side_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (side_f),
    .q_o    (side_m)
  );

  hgp_back #(.OUT_F(OUT_FRAC_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .side_i   (side_m),
    .q_i      (q_al),
    .v_i      (v_full[V_W-1:0]),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks henyey_greenstein_pdf_unit: a table of directed direction pairs,
// then random pairs under several asymmetry settings, each result compared
// against a fixed table value or a bit-true phase density predictor, kept in an expectation queue.
// ----------------------------------------------------------------------------
module testbench;
  import hgp_pkg::*;

  localparam int unsigned LATENCY   = 93;
  localparam int unsigned N_RANDOM  = 1530;
  localparam longint      CYCLE_CAP = 400000;

  typedef struct packed {
    logic        chk;
    logic [31:0] density;
    logic        saturated;
  } hgp_exp_t;

  typedef struct {
    hgp_in_t     pair;
    logic        fixed;
    logic [31:0] density;
    logic        saturated;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic signed [15:0] cfg_data_i;
  logic              start;
  logic              busy;
  hgp_in_t           in_data_i;
  logic              result_valid_o;
  hgp_out_t          result_o;

  hgp_exp_t          density_q[$];
  logic signed [15:0] g_model;
  int                errors;
  longint            cycles;

  henyey_greenstein_pdf_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .in_data_i     (in_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic hgp_out_t phase_density(hgp_in_t p, logic signed [15:0] g);
    longint      dot;
    longint      d;
    longint      scale;
    longint      gg;
    longint      t;
    longint      num;
    logic [63:0] t30;
    logic [63:0] n30;
    logic [63:0] q;
    logic [63:0] s;
    logic [63:0] v;
    logic [127:0] prod;
    logic [63:0] x;
    hgp_out_t    r;
    dot = longint'(p.in_x) * p.out_x + longint'(p.in_y) * p.out_y
        + longint'(p.in_z) * p.out_z;
    if (dot > (64'sd1 <<< 30)) dot = 64'sd1 <<< 30;
    if (dot < -(64'sd1 <<< 30)) dot = -(64'sd1 <<< 30);
    d = dot;
    scale = 64'sd1 <<< 45;
    gg = longint'(g) * longint'(g) * (64'sd1 <<< 15);
    t = scale + gg + 2 * longint'(g) * d;
    num = scale - gg;
    if (t < 0) t = 0;
    if (num < 0) num = 0;
    t30 = 64'(t) >> 15;
    n30 = 64'(num) >> 15;
    r.density = SAT_VALUE;
    r.saturated = 1'b1;
    if (t30 == 0) return r;
    if (n30 == 0) begin
      r.density = 0;
      r.saturated = 1'b0;
      return r;
    end
    q = (n30 << 30) / t30;
    s = int_sqrt(t30 << 16);
    if (s == 0) return r;
    v = (64'd1 << 53) / s;
    prod = 128'(q) * 128'(v);
    if ((prod >> 92) != 0) return r;
    x = prod[91:28];
    prod = 128'(x) * 128'(64'h145F306E);
    if ((prod >> 80) != 0) return r;
    r.density = prod[79:48];
    r.saturated = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
        $display("henyey_greenstein_pdf_unit: mismatch");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    hgp_exp_t e;
    if (rst_ni && result_valid_o) begin
      if (density_q.size() == 0) begin
        $error("unexpected result density=%h", result_o.density);
        errors++;
      end else begin
        e = density_q.pop_front();
        if (e.density !== result_o.density) begin
          $error("density: expected %h, got %h", e.density, result_o.density);
          errors++;
        end
        if (e.saturated !== result_o.saturated) begin
          $error("saturated: expected %b, got %b", e.saturated, result_o.saturated);
          errors++;
        end
      end
    end
  end

  task automatic write_g(logic signed [15:0] g);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    g_model = g;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (density_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic send_pair(hgp_in_t p, logic fixed, logic [31:0] dens, logic sat,
                           bit idle_ok);
    hgp_out_t r;
    hgp_exp_t e;
    while (idle_ok && $urandom_range(99) < 26) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (busy);
    r = phase_density(p, g_model);
    e.chk = 1'b1;
    if (fixed) begin
      e.density = dens;
      e.saturated = sat;
    end else begin
      e.density = r.density;
      e.saturated = r.saturated;
    end
    density_q.push_back(e);
  endtask

  function automatic hgp_in_t mk(int ax, int ay, int az, int bx, int by, int bz);
    hgp_in_t p;
    p.in_x = 16'(ax); p.in_y = 16'(ay); p.in_z = 16'(az);
    p.out_x = 16'(bx); p.out_y = 16'(by); p.out_z = 16'(bz);
    return p;
  endfunction

  function automatic hgp_in_t rnd_pair(int mode);
    hgp_in_t p;
    int k;
    p = hgp_in_t'({$urandom, $urandom, $urandom});
    if (mode == 0) begin
      // near-unit incoming direction: one large component, others small; outgoing x unrestricted, y and z small
      k = $urandom_range(2);
      p.in_x = 16'($urandom_range(2047)) - 16'd1024;
      p.in_y = 16'($urandom_range(2047)) - 16'd1024;
      p.in_z = 16'($urandom_range(2047)) - 16'd1024;
      p.out_x = 16'($urandom_range(65535));
      p.out_y = 16'($urandom_range(4095)) - 16'd2048;
      p.out_z = 16'($urandom_range(4095)) - 16'd2048;
      case (k)
        0: p.in_x = $urandom_range(1) ? 16'sh7F00 : 16'sh8100;
        1: p.in_y = $urandom_range(1) ? 16'sh7F00 : 16'sh8100;
        default: p.in_z = $urandom_range(1) ? 16'sh7F00 : 16'sh8100;
      endcase
    end
    return p;
  endfunction

  initial begin
    dir_row_t dirs[$];
    logic signed [15:0] g_set[6];
    hgp_in_t p;
    int n;
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    start = 1'b0;
    in_data_i = '0;
    g_model = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // g = 0 after reset: density is 1/(4 pi) for any direction pair
    dirs.push_back('{mk(32767, 0, 0, 32767, 0, 0), 0, 0, 0});
    dirs.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768), 0, 0, 0});
    dirs.push_back('{mk(0, 0, 0, 0, 0, 0), 0, 0, 0});
    dirs.push_back('{mk(-32768, 0, 0, 32767, 0, 0), 0, 0, 0});
    foreach (dirs[i]) send_pair(dirs[i].pair, dirs[i].fixed, dirs[i].density,
                                dirs[i].saturated, 1);
    drain();

    // g = -1: numerator zero gives density 0, unless t is zero first
    write_g(-16'sd32768);
    dirs.delete();
    dirs.push_back('{mk(-32768, 0, 0, -32768, 0, 0), 1, SAT_VALUE, 1});
    dirs.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767), 1, SAT_VALUE, 1});
    dirs.push_back('{mk(-32768, 0, 0, 32767, 0, 0), 1, 32'd0, 0});
    dirs.push_back('{mk(0, 0, 0, 0, 0, 0), 1, 32'd0, 0});
    foreach (dirs[i]) send_pair(dirs[i].pair, dirs[i].fixed, dirs[i].density,
                                dirs[i].saturated, 1);
    drain();

    // g near +1: forward peak, overflow and clamping
    write_g(16'sd32767);
    dirs.delete();
    dirs.push_back('{mk(32767, 0, 0, 32767, 0, 0), 0, 0, 0});
    dirs.push_back('{mk(-32768, -32768, 0, -32768, -32768, 0), 0, 0, 0});
    dirs.push_back('{mk(-32768, 0, 0, -32768, 0, 0), 0, 0, 0});
    dirs.push_back('{mk(-32768, 0, 0, 32767, 0, 0), 0, 0, 0});
    dirs.push_back('{mk(32767, 32767, 32767, -32768, -32768, -32768), 0, 0, 0});
    dirs.push_back('{mk(0, 23170, 23170, 0, 23170, -23170), 0, 0, 0});
    dirs.push_back('{mk(-1, -1, -1, 1, 1, 1), 0, 0, 0});
    foreach (dirs[i]) send_pair(dirs[i].pair, dirs[i].fixed, dirs[i].density,
                                dirs[i].saturated, 1);
    drain();

    g_set = '{16'sd16384, -16'sd9830, 16'sd32000, -16'sd32768, 16'sd1, 16'sd0};
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_g(ph == 5 ? 16'($urandom) : g_set[ph]);
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        p = rnd_pair($urandom_range(99) < 75 ? 0 : 1);
        // one stretch without gaps in the second phase
        send_pair(p, 0, 0, 0, !(ph == 1 && i < 150));
        n++;
        if (ph == 2 && i == 100) begin
          start <= 1'b0;
          while (density_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("henyey_greenstein_pdf_unit: match");
    end else begin
      $display("henyey_greenstein_pdf_unit: mismatch");
    end
    $finish;
  end

endmodule
